// File: sv/aspan_pkg.sv
// Shared types and constants of the alpha run span encoder.
`timescale 1ns / 1ps
`default_nettype none
package aspan_pkg;

	localparam int COORD_LIMIT_DEF = 1024;
	localparam int QUEUE_DEPTH_DEF = 4;

	localparam int ALPHA_W = 8;
	localparam int LEVEL_W = 8;
	localparam int X_W = 10;
	localparam int ROW_W = 10;
	localparam int WIDTH_W = 11;
	localparam int S_DATA_W = 8;
	localparam int S_USER_W = 2;
	localparam int M_DATA_W = 40;

	localparam logic [LEVEL_W-1:0] LEVEL_MAX = 8'd255;
	localparam logic [ALPHA_W:0] ROUND_ADD = 9'd15;
	localparam logic [ALPHA_W:0] ROUND_MASK = ~9'd15;

	// One classified pixel as it waits between the front and the back.
	typedef struct packed {
		logic nz;
		logic [LEVEL_W-1:0] level;
		logic row_end;
		logic glyph_end;
	} pix_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	typedef struct packed {
		logic [X_W-1:0] x;
		logic [ROW_W-1:0] row;
		logic [WIDTH_W-1:0] width;
		logic [LEVEL_W-1:0] level;
		logic last;
	} span_t;

	function automatic logic [LEVEL_W-1:0] quantize(input logic [ALPHA_W-1:0] alpha);
		logic [ALPHA_W:0] sum;
		sum = ({1'b0, alpha} + ROUND_ADD) & ROUND_MASK;
		return sum[ALPHA_W] ? LEVEL_MAX : sum[LEVEL_W-1:0];
	endfunction

endpackage
`default_nettype wire

// File: sv/aspan_front.sv
// Front end: accepts pixels and classifies them into queue entries.
`timescale 1ns / 1ps
`default_nettype none
module aspan_front (
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	input  wire logic [aspan_pkg::S_DATA_W-1:0]  s_tdata,   // alpha
	input  wire logic [aspan_pkg::S_USER_W-1:0]  s_tuser,   // off_texture, glyph_end
	input  wire logic                            s_tlast,   // row_end
	input  wire aspan_pkg::q_status_t            q_status,
	output logic                                 push,
	output aspan_pkg::pix_t                      push_data
);
	import aspan_pkg::*;

	logic [ALPHA_W-1:0] alpha;

	assign alpha = s_tdata[ALPHA_W-1:0];
	assign s_tready = !q_status.full;
	assign push = s_tvalid && s_tready;

	always_comb begin
		push_data.nz = !s_tuser[0] && (alpha != '0);
		push_data.level = quantize(alpha);
		push_data.row_end = s_tlast;
		push_data.glyph_end = s_tuser[1];
	end

endmodule
`default_nettype wire

// File: sv/aspan_queue.sv
// Short queue of classified pixels between the front and the back.
`timescale 1ns / 1ps
`default_nettype none
module aspan_queue #(
	parameter int DEPTH = aspan_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire aspan_pkg::pix_t  push_data,
	input  wire logic             pop,
	output aspan_pkg::pix_t       head,
	output aspan_pkg::q_status_t  status
);
	import aspan_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	pix_t entry_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign status.full = (count_q == CW'(DEPTH));
	assign status.empty = (count_q == '0);
	assign head = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= bump(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= bump(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef SYNTH
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		status.full && !pop |-> !push) else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		status.empty |-> !pop) else $error("queue read while empty");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> count_q == $past(count_q) + 1'b1) else $error("count slip");
`endif

endmodule
`default_nettype wire

// File: sv/aspan_back.sv
// Back end: run tracking, span generation and the output register.
`timescale 1ns / 1ps
`default_nettype none
module aspan_back #(
	parameter int COORD_LIMIT = aspan_pkg::COORD_LIMIT_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire aspan_pkg::pix_t                 head,
	input  wire aspan_pkg::q_status_t            q_status,
	output logic                                 pop,
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	output logic [aspan_pkg::M_DATA_W-1:0]       m_tdata,   // span_x, span_row, span_width, span_level
	output logic                                 m_tlast    // final_of_item
);
	import aspan_pkg::*;

	localparam int CW = $clog2(COORD_LIMIT);
	localparam int LW = $clog2(COORD_LIMIT + 1);

	logic [CW-1:0] col_q;
	logic [CW-1:0] row_q;
	logic [CW-1:0] run_start_q;
	logic [LW-1:0] run_len_q;
	logic [LEVEL_W-1:0] run_level_q;

	span_t out_q;
	logic out_valid_q;
	span_t pend_q;
	logic pend_valid_q;

	logic out_free;
	logic run_open;
	logic same;
	logic emit_a;
	logic emit_b;
	logic line_done;
	logic [LW-1:0] len_inc;
	span_t span_a;
	span_t span_b;

	function automatic logic [CW-1:0] next_coord(input logic [CW-1:0] v);
		logic [CW:0] n;
		n = {1'b0, v} + 1'b1;
		return (n >= (CW + 1)'(COORD_LIMIT)) ? '0 : n[CW-1:0];
	endfunction

	assign out_free = !out_valid_q || m_tready;
	assign pop = !q_status.empty && !pend_valid_q && out_free;

	assign run_open = (run_len_q != '0);
	assign same = run_open && head.nz && (run_level_q == head.level);
	assign line_done = head.row_end || head.glyph_end;
	assign emit_a = run_open && !same;
	assign emit_b = line_done && head.nz;
	assign len_inc = (run_len_q < LW'(COORD_LIMIT)) ? run_len_q + 1'b1 : run_len_q;

	always_comb begin
		span_a.x = X_W'(run_start_q);
		span_a.row = ROW_W'(row_q);
		span_a.width = WIDTH_W'(run_len_q);
		span_a.level = run_level_q;
		span_a.last = !emit_b;
		span_b.row = ROW_W'(row_q);
		span_b.last = 1'b1;
		if (same) begin
			span_b.x = X_W'(run_start_q);
			span_b.width = WIDTH_W'(len_inc);
			span_b.level = run_level_q;
		end else begin
			span_b.x = X_W'(col_q);
			span_b.width = WIDTH_W'(1);
			span_b.level = head.level;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (pend_valid_q) begin
				out_q <= pend_q;
			end else if (pop && emit_a) begin
				out_q <= span_a;
			end else if (pop && emit_b) begin
				out_q <= span_b;
			end
		end
		if (pop && emit_a) begin
			pend_q <= span_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pend_valid_q <= 1'b0;
			col_q <= '0;
			row_q <= '0;
			run_start_q <= '0;
			run_len_q <= '0;
			run_level_q <= '0;
		end else begin
			if (out_free) begin
				if (pend_valid_q) begin
					out_valid_q <= 1'b1;
					pend_valid_q <= 1'b0;
				end else begin
					out_valid_q <= pop && (emit_a || emit_b);
					pend_valid_q <= pop && emit_a && emit_b;
				end
			end
			if (pop) begin
				if (line_done || !head.nz) begin
					run_len_q <= '0;
				end else if (same) begin
					run_len_q <= len_inc;
				end else begin
					run_len_q <= LW'(1);
				end
				if (head.nz && !same) begin
					run_start_q <= col_q;
					run_level_q <= head.level;
				end
				if (head.glyph_end) begin
					col_q <= '0;
					row_q <= '0;
				end else if (head.row_end) begin
					col_q <= '0;
					row_q <= next_coord(row_q);
				end else begin
					col_q <= next_coord(col_q);
				end
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = {1'b0, out_q.level, out_q.width, out_q.row, out_q.x};
	assign m_tlast = out_q.last;

`ifndef SYNTH
	a_pend_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		pend_valid_q |-> out_valid_q) else $error("second span without a first");
	a_pend_holds_pop: assert property (@(posedge clk) disable iff (!arst_n)
		pend_valid_q |-> !pop) else $error("pixel taken while a span waits");
	a_open_run_level: assert property (@(posedge clk) disable iff (!arst_n)
		run_len_q != '0 |-> run_level_q != '0) else $error("open run without a level");
	a_run_len_cap: assert property (@(posedge clk) disable iff (!arst_n)
		run_len_q <= LW'(COORD_LIMIT)) else $error("run length beyond limit");
	a_pend_last: assert property (@(posedge clk) disable iff (!arst_n)
		pend_valid_q |-> pend_q.last && !out_q.last) else $error("final flag misplaced");
`endif

endmodule
`default_nettype wire

// File: sv/alpha_run_span_encoder.sv
// Top level of the alpha run span encoder.
`timescale 1ns / 1ps
`default_nettype none
// Takes one glyph pixel per clock while the queue is not full (alpha in s_tdata, row
// end in s_tlast, off-texture and glyph end in s_tuser bits 0 and 1) and emits merged
// spans of equal quantized level. Only a pixel that closes a span and also ends its row
// or glyph with a new one yields two spans; the back end takes no further pixel until
// the second has left the pending register. A queue of QUEUE_DEPTH pixels lets the
// input keep streaming while the output stalls. Coordinates wrap at COORD_LIMIT. With
// the queue empty, a taken pixel passes the queue entry and then the output register.
module alpha_run_span_encoder #(
	parameter int COORD_LIMIT = aspan_pkg::COORD_LIMIT_DEF,
	parameter int QUEUE_DEPTH = aspan_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	input  wire logic [aspan_pkg::S_DATA_W-1:0]  s_tdata,   // alpha
	input  wire logic [aspan_pkg::S_USER_W-1:0]  s_tuser,   // off_texture, glyph_end
	input  wire logic                            s_tlast,   // row_end
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	output logic [aspan_pkg::M_DATA_W-1:0]       m_tdata,   // span_x, span_row, span_width, span_level
	output logic                                 m_tlast    // final_of_item
);
	import aspan_pkg::*;

	q_status_t q_status;
	logic push;
	logic pop;
	pix_t push_data;
	pix_t head;

	aspan_front u_front (
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.q_status  (q_status),
		.push      (push),
		.push_data (push_data)
	);

	aspan_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.status    (q_status)
	);

	aspan_back #(
		.COORD_LIMIT (COORD_LIMIT)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.q_status (q_status),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule
`default_nettype wire
